FILE: rtl/pimt_pkg.sv
package pimt_pkg;

    localparam int NUM_MUTEXES = 16;
    localparam int MAX_TASKS   = 32;
    localparam int PRIO_BITS   = 5;
    localparam int HOLD_BITS   = 8;

    localparam int H_W    = $clog2(NUM_MUTEXES);
    localparam int Q_W    = $clog2(MAX_TASKS);
    localparam int LEN_W  = $clog2(MAX_TASKS + 1);
    localparam int ENT_W  = 5 + PRIO_BITS;
    localparam int ADDR_W = H_W + Q_W;
    localparam int MEM_D  = NUM_MUTEXES * MAX_TASKS;

    localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

    typedef enum logic [1:0] {
        K_CREATE  = 2'd0,
        K_LOCK    = 2'd1,
        K_UNLOCK  = 2'd2,
        K_DESTROY = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_BAD_HANDLE = 4'd1,
        ST_NOT_CREATED = 4'd2,
        ST_POOL_FULL  = 4'd3,
        ST_IN_INTR    = 4'd4,
        ST_SUSPENDED  = 4'd5,
        ST_TRY_FAILED = 4'd6,
        ST_UNHELD     = 4'd7,
        ST_NOT_OWNER  = 4'd8,
        ST_HAS_WAITERS = 4'd9,
        ST_HELD       = 4'd10,
        ST_BLOCKED    = 4'd11,
        ST_NEST_LIMIT = 4'd12
    } status_t;

    // Command after front-end screening; bad-handle commands come through with
    // bad_handle set and are answered without touching the table.
    typedef struct packed {
        logic [1:0]           kind;
        logic [H_W-1:0]       handle;
        logic [4:0]           task_id;
        logic [PRIO_BITS-1:0] prio;
        logic                 may_wait;
        logic                 in_interrupt;
        logic                 sched_suspended;
        logic                 bad_handle;
    } cmd_t;

    typedef struct packed {
        logic [3:0]           status;
        logic [3:0]           new_handle;
        logic                 prio_change_valid;
        logic [4:0]           prio_change_task;
        logic [4:0]           prio_change_value;
        logic                 wake_valid;
        logic [4:0]           wake_task;
    } result_t;

endpackage

FILE: rtl/pimt_if.sv
interface pimt_cmd_if (input logic clk);
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] handle;
    logic [4:0] task_id;
    logic [4:0] task_priority;
    logic       may_wait;
    logic       in_interrupt;
    logic       sched_suspended;

    modport source (output valid, kind, handle, task_id, task_priority, may_wait,
                    in_interrupt, sched_suspended, input ready);
    modport sink (input valid, kind, handle, task_id, task_priority, may_wait,
                  in_interrupt, sched_suspended, output ready);
endinterface

interface pimt_res_if (input logic clk);
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [3:0] new_handle;
    logic       prio_change_valid;
    logic [4:0] prio_change_task;
    logic [4:0] prio_change_value;
    logic       wake_valid;
    logic [4:0] wake_task;

    modport source (output valid, status, new_handle, prio_change_valid,
                    prio_change_task, prio_change_value, wake_valid, wake_task,
                    input ready);
    modport sink (input valid, status, new_handle, prio_change_valid,
                  prio_change_task, prio_change_value, wake_valid, wake_task,
                  output ready);
endinterface

FILE: rtl/pimt_ram.sv
module pimt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/pimt_front.sv
module pimt_front (
    input  logic                clk,
    input  logic                rst_n,
    pimt_cmd_if.sink            cmd,
    output logic                q_valid,
    output pimt_pkg::cmd_t      q_cmd,
    input  logic                q_pop
);
    // Two-entry queue between screening and execution.
    pimt_pkg::cmd_t fifo_reg [2];
    logic [1:0]     count_reg;
    logic           rd_reg;
    logic           wr_reg;
    pimt_pkg::cmd_t cmd_in;
    logic           push;

    assign cmd.ready = (count_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_cmd     = fifo_reg[rd_reg];

    always_comb
    begin
        cmd_in.kind            = cmd.kind;
        cmd_in.handle          = cmd.handle[pimt_pkg::H_W-1:0];
        cmd_in.task_id         = cmd.task_id;
        cmd_in.prio            = cmd.task_priority[pimt_pkg::PRIO_BITS-1:0];
        cmd_in.may_wait        = cmd.may_wait;
        cmd_in.in_interrupt    = cmd.in_interrupt;
        cmd_in.sched_suspended = cmd.sched_suspended;
        cmd_in.bad_handle      = (cmd.kind != pimt_pkg::K_CREATE) &&
                                 (cmd.handle >= 8'(pimt_pkg::NUM_MUTEXES));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (count_reg == 2'd2 && !q_pop) |=> count_reg == 2'd2)
        else $error("queue lost an entry");
endmodule

FILE: rtl/pimt_back.sv
module pimt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  pimt_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    pimt_res_if.source          res
);
    localparam int H_W   = pimt_pkg::H_W;
    localparam int Q_W   = pimt_pkg::Q_W;
    localparam int LEN_W = pimt_pkg::LEN_W;
    localparam int P_W   = pimt_pkg::PRIO_BITS;
    localparam int E_W   = pimt_pkg::ENT_W;
    localparam int A_W   = pimt_pkg::ADDR_W;
    localparam int NM    = pimt_pkg::NUM_MUTEXES;
    localparam int HB    = pimt_pkg::HOLD_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_SHIFT_UP, S_SHIFT_DN, S_OUT
    } state_t;

    logic [NM-1:0]  in_use_reg;
    logic [4:0]     owner_reg [NM];
    logic [HB-1:0]  hold_reg  [NM];
    logic [P_W-1:0] base_reg  [NM];
    logic [P_W-1:0] cur_reg   [NM];
    logic [LEN_W-1:0] len_reg [NM];

    state_t           state_reg;
    pimt_pkg::cmd_t   c_reg;
    pimt_pkg::result_t r_reg;
    logic [LEN_W-1:0] idx_reg;   // walking index
    logic [LEN_W-1:0] pos_reg;

    logic           we;
    logic [A_W-1:0] waddr;
    logic [A_W-1:0] raddr;
    logic [E_W-1:0] wdata;
    logic [E_W-1:0] rdata;

    pimt_ram #(.WIDTH(E_W), .DEPTH(pimt_pkg::MEM_D)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [H_W-1:0] h;
    logic [H_W-1:0] free_idx;
    logic           free_any;
    logic [LEN_W-1:0] len;
    logic [P_W-1:0] ent_prio;
    logic           scan_stop;
    state_t         dec_state;

    assign h         = c_reg.handle;
    assign len       = len_reg[h];
    assign ent_prio  = rdata[P_W-1:0];
    assign scan_stop = !(idx_reg < len && ent_prio >= c_reg.prio);

    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NM - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_idx = H_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // Where the decision leaves the table walk to later states
    always_comb
    begin
        dec_state = S_OUT;
        if (c_reg.kind == pimt_pkg::K_LOCK && !c_reg.bad_handle && in_use_reg[h] &&
            !c_reg.in_interrupt && !c_reg.sched_suspended && hold_reg[h] != '0 &&
            owner_reg[h] != c_reg.task_id && c_reg.may_wait &&
            len != LEN_W'(pimt_pkg::MAX_TASKS))
        begin
            dec_state = S_SCAN;
        end
        else if (c_reg.kind == pimt_pkg::K_UNLOCK && !c_reg.bad_handle && in_use_reg[h] &&
                 !c_reg.in_interrupt && !c_reg.sched_suspended &&
                 hold_reg[h] == HB'(1) && owner_reg[h] == c_reg.task_id &&
                 len > LEN_W'(1))
        begin
            dec_state = S_SHIFT_DN;
        end
    end

    // Memory addressing per state. Read data is registered: it arrives in the cycle after raddr.
    always_comb
    begin
        we    = 1'b0;
        waddr = {h, idx_reg[Q_W-1:0]};
        wdata = rdata;
        raddr = {h, idx_reg[Q_W-1:0]};
        unique case (state_reg)
            S_IDLE:
            begin
                // head entry of the incoming command's queue
                raddr = {q_cmd.handle, Q_W'(0)};
            end
            S_DECIDE:
            begin
                // scan starts at entry 0, shift-down starts from entry 1
                raddr = {h, (c_reg.kind == pimt_pkg::K_UNLOCK) ? Q_W'(1) : Q_W'(0)};
            end
            S_SCAN:
            begin
                // on the last scan step fetch the tail for the shift-up
                if (scan_stop)
                begin
                    raddr = {h, Q_W'(len - 1'b1)};
                end
                else
                begin
                    raddr = {h, Q_W'(idx_reg + 1'b1)};
                end
            end
            S_SHIFT_UP:
            begin
                // idx_reg is the destination; rdata holds entry idx-1
                if (idx_reg == pos_reg)
                begin
                    we    = 1'b1;
                    wdata = {c_reg.task_id, c_reg.prio};
                end
                else
                begin
                    we = 1'b1;
                end
                raddr = {h, Q_W'(idx_reg - LEN_W'(2))};
            end
            S_SHIFT_DN:
            begin
                // rdata holds entry idx+1, written to idx
                we    = 1'b1;
                raddr = {h, Q_W'(idx_reg + LEN_W'(2))};
            end
            default:
            begin
            end
        endcase
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign res.valid = (state_reg == S_OUT);
    assign res.status            = r_reg.status;
    assign res.new_handle        = r_reg.new_handle;
    assign res.prio_change_valid = r_reg.prio_change_valid;
    assign res.prio_change_task  = r_reg.prio_change_task;
    assign res.prio_change_value = r_reg.prio_change_value;
    assign res.wake_valid        = r_reg.wake_valid;
    assign res.wake_task         = r_reg.wake_task;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            c_reg <= q_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            in_use_reg <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            r_reg      <= '0;
            for (int i = 0; i < NM; i++)
            begin
                owner_reg[i] <= '0;
                hold_reg[i]  <= '0;
                base_reg[i]  <= '0;
                cur_reg[i]   <= '0;
                len_reg[i]   <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_DECIDE;
                        idx_reg   <= '0;
                        r_reg     <= '0;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= dec_state;
                    if (c_reg.kind == pimt_pkg::K_CREATE)
                    begin
                        if (free_any)
                        begin
                            in_use_reg[free_idx] <= 1'b1;
                            owner_reg[free_idx]  <= '0;
                            hold_reg[free_idx]   <= '0;
                            base_reg[free_idx]   <= '0;
                            cur_reg[free_idx]    <= '0;
                            len_reg[free_idx]    <= '0;
                            r_reg.new_handle     <= 4'(free_idx);
                        end
                        else
                        begin
                            r_reg.status <= pimt_pkg::ST_POOL_FULL;
                        end
                    end
                    else if (c_reg.bad_handle)
                    begin
                        r_reg.status <= pimt_pkg::ST_BAD_HANDLE;
                    end
                    else if (!in_use_reg[h])
                    begin
                        r_reg.status <= pimt_pkg::ST_NOT_CREATED;
                    end
                    else if (c_reg.kind == pimt_pkg::K_DESTROY)
                    begin
                        if (len != '0)
                        begin
                            r_reg.status <= pimt_pkg::ST_HAS_WAITERS;
                        end
                        else if (hold_reg[h] != '0)
                        begin
                            r_reg.status <= pimt_pkg::ST_HELD;
                        end
                        else
                        begin
                            in_use_reg[h] <= 1'b0;
                            owner_reg[h]  <= '0;
                            base_reg[h]   <= '0;
                            cur_reg[h]    <= '0;
                        end
                    end
                    else if (c_reg.in_interrupt)
                    begin
                        r_reg.status <= pimt_pkg::ST_IN_INTR;
                    end
                    else if (c_reg.sched_suspended)
                    begin
                        r_reg.status <= pimt_pkg::ST_SUSPENDED;
                    end
                    else if (c_reg.kind == pimt_pkg::K_LOCK)
                    begin
                        if (hold_reg[h] == '0)
                        begin
                            owner_reg[h] <= c_reg.task_id;
                            base_reg[h]  <= c_reg.prio;
                            cur_reg[h]   <= c_reg.prio;
                            hold_reg[h]  <= HB'(1);
                        end
                        else if (owner_reg[h] == c_reg.task_id)
                        begin
                            if (hold_reg[h] == pimt_pkg::HOLD_MAX)
                            begin
                                r_reg.status <= pimt_pkg::ST_NEST_LIMIT;
                            end
                            else
                            begin
                                hold_reg[h] <= hold_reg[h] + HB'(1);
                            end
                        end
                        else if (!c_reg.may_wait ||
                                 len == LEN_W'(pimt_pkg::MAX_TASKS))
                        begin
                            r_reg.status <= pimt_pkg::ST_TRY_FAILED;
                        end
                        else
                        begin
                            r_reg.status <= pimt_pkg::ST_BLOCKED;
                            if (c_reg.prio > cur_reg[h])
                            begin
                                cur_reg[h]              <= c_reg.prio;
                                r_reg.prio_change_valid <= 1'b1;
                                r_reg.prio_change_task  <= owner_reg[h];
                                r_reg.prio_change_value <= 5'(c_reg.prio);
                            end
                        end
                    end
                    else
                    begin
                        if (hold_reg[h] == '0)
                        begin
                            r_reg.status <= pimt_pkg::ST_UNHELD;
                        end
                        else if (owner_reg[h] != c_reg.task_id)
                        begin
                            r_reg.status <= pimt_pkg::ST_NOT_OWNER;
                        end
                        else if (hold_reg[h] != HB'(1))
                        begin
                            hold_reg[h] <= hold_reg[h] - HB'(1);
                        end
                        else
                        begin
                            if (c_reg.prio != base_reg[h])
                            begin
                                r_reg.prio_change_valid <= 1'b1;
                                r_reg.prio_change_task  <= owner_reg[h];
                                r_reg.prio_change_value <= 5'(base_reg[h]);
                            end
                            if (len != '0)
                            begin
                                // rdata holds the head waiter
                                owner_reg[h]     <= rdata[E_W-1:P_W];
                                base_reg[h]      <= ent_prio;
                                cur_reg[h]       <= ent_prio;
                                r_reg.wake_valid <= 1'b1;
                                r_reg.wake_task  <= rdata[E_W-1:P_W];
                                len_reg[h]       <= len - 1'b1;
                            end
                            else
                            begin
                                hold_reg[h]  <= '0;
                                owner_reg[h] <= '0;
                                base_reg[h]  <= '0;
                                cur_reg[h]   <= '0;
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    // rdata = entry idx_reg
                    if (!scan_stop)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        pos_reg <= idx_reg;
                        idx_reg <= len;
                        if (idx_reg == len)
                        begin
                            len_reg[h] <= len + 1'b1;
                            state_reg  <= S_SHIFT_UP;
                        end
                        else
                        begin
                            state_reg  <= S_SHIFT_UP;
                            len_reg[h] <= len + 1'b1;
                        end
                    end
                end
                S_SHIFT_UP:
                begin
                    // idx_reg counts down from the old length to the insert slot
                    if (idx_reg == pos_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                S_SHIFT_DN:
                begin
                    if (idx_reg + LEN_W'(1) >= len)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (res.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
                     res.valid && !res.ready |=> res.valid && $stable(res.status))
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
                     state_reg == S_DECIDE |-> $past(q_pop))
        else $error("decide without a command");
    assert property (@(posedge clk) disable iff (!rst_n)
                     res.valid && res.wake_valid |-> res.status == pimt_pkg::ST_OK)
        else $error("wake with error status");
endmodule

FILE: rtl/priority_inheritance_mutex_table.sv
// Channel | Dir | Payload
// cmd     | in  | kind, handle, task_id, task_priority, may_wait, in_interrupt,
//         |     | sched_suspended
// res     | out | status, new_handle, prio_change_*, wake_*
// A command passes through the idle, decide and output states plus the
// wait-queue walk: a blocking lock scans then shifts one entry per cycle,
// and the final unlock with waiters shifts the queue down. The single RAM
// port pair holding the wait queues sets the pace of the walk.
// Reset clears the whole table at once; no clearing pass is needed.
// A stalled result holds the back end; two commands queue in front.
module priority_inheritance_mutex_table (
    input logic        clk,
    input logic        rst_n,
    pimt_cmd_if.sink   cmd,
    pimt_res_if.source res
);
    logic           q_valid;
    logic           q_pop;
    pimt_pkg::cmd_t q_cmd;

    pimt_front u_front (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    pimt_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop), .res(res)
    );
endmodule

FILE: verif/priority_inheritance_mutex_table_tb.sv
module priority_inheritance_mutex_table_tb;

    logic clk;
    logic rst_n;

    pimt_cmd_if cmd (clk);
    pimt_res_if res (clk);

    priority_inheritance_mutex_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    typedef struct {
        pimt_pkg::kind_t   kind;
        bit [7:0]          handle;
        bit [4:0]          task_id;
        bit [4:0]          prio;
        bit                may_wait;
        bit                intr;
        bit                susp;
        bit                typed;
        pimt_pkg::status_t exp_status;
        bit [3:0]          exp_handle;
    } cmd_row_t;

    typedef struct {
        bit                typed;
        pimt_pkg::result_t res;
    } typed_exp_t;

    // shadow of the mutex table
    bit       mx_used  [pimt_pkg::NUM_MUTEXES];
    bit [4:0] mx_owner [pimt_pkg::NUM_MUTEXES];
    bit [7:0] mx_holds [pimt_pkg::NUM_MUTEXES];
    bit [4:0] mx_base  [pimt_pkg::NUM_MUTEXES];
    bit [4:0] mx_cur   [pimt_pkg::NUM_MUTEXES];
    bit [4:0] wq_task  [pimt_pkg::NUM_MUTEXES][pimt_pkg::MAX_TASKS];
    bit [4:0] wq_prio  [pimt_pkg::NUM_MUTEXES][pimt_pkg::MAX_TASKS];
    int       wq_len   [pimt_pkg::NUM_MUTEXES];

    pimt_pkg::result_t pending_results[$];
    typed_exp_t        typed_q[$];

    int src_idle;
    int dst_idle;
    int phase;
    int hold_count_cycles;
    int mismatches;
    int n_cmds;
    int n_results;
    int n_blocked;
    int n_wakes;
    int n_boosts;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #10_000_000;
        $display("priority_inheritance_mutex_table regression: fail");
        $finish;
    end

    function automatic pimt_pkg::result_t mutex_table_step(pimt_pkg::kind_t kind,
                                                           bit [7:0] hdl, bit [4:0] tsk,
                                                           bit [4:0] prio, bit may_wait,
                                                           bit intr, bit susp);
        pimt_pkg::result_t r;
        int                h;
        int                pos;
        r = '0;
        h = hdl;
        if (kind == pimt_pkg::K_CREATE)
        begin
            r.status = pimt_pkg::ST_POOL_FULL;
            for (int i = 0; i < pimt_pkg::NUM_MUTEXES; i++)
            begin
                if (!mx_used[i] && r.status == pimt_pkg::ST_POOL_FULL)
                begin
                    mx_used[i]  = 1'b1;
                    mx_owner[i] = '0;
                    mx_holds[i] = '0;
                    mx_base[i]  = '0;
                    mx_cur[i]   = '0;
                    wq_len[i]   = 0;
                    r.status     = pimt_pkg::ST_OK;
                    r.new_handle = 4'(i);
                end
            end
        end
        else if (h >= pimt_pkg::NUM_MUTEXES)
            r.status = pimt_pkg::ST_BAD_HANDLE;
        else if (!mx_used[h])
            r.status = pimt_pkg::ST_NOT_CREATED;
        else if (kind == pimt_pkg::K_DESTROY)
        begin
            if (wq_len[h] != 0)
                r.status = pimt_pkg::ST_HAS_WAITERS;
            else if (mx_holds[h] != 0)
                r.status = pimt_pkg::ST_HELD;
            else
            begin
                mx_used[h]  = 1'b0;
                mx_owner[h] = '0;
                mx_base[h]  = '0;
                mx_cur[h]   = '0;
            end
        end
        else if (intr)
            r.status = pimt_pkg::ST_IN_INTR;
        else if (susp)
            r.status = pimt_pkg::ST_SUSPENDED;
        else if (kind == pimt_pkg::K_LOCK)
        begin
            if (mx_holds[h] == 0)
            begin
                mx_owner[h] = tsk;
                mx_base[h]  = prio;
                mx_cur[h]   = prio;
                mx_holds[h] = 8'd1;
            end
            else if (mx_owner[h] == tsk)
            begin
                if (mx_holds[h] == pimt_pkg::HOLD_MAX)
                    r.status = pimt_pkg::ST_NEST_LIMIT;
                else
                    mx_holds[h]++;
            end
            else if (!may_wait || wq_len[h] >= pimt_pkg::MAX_TASKS)
                r.status = pimt_pkg::ST_TRY_FAILED;
            else
            begin
                if (prio > mx_cur[h])
                begin
                    mx_cur[h]           = prio;
                    r.prio_change_valid = 1'b1;
                    r.prio_change_task  = mx_owner[h];
                    r.prio_change_value = prio;
                end
                pos = 0;
                while (pos < wq_len[h] && wq_prio[h][pos] >= prio)
                    pos++;
                for (int k = wq_len[h]; k > pos; k--)
                begin
                    wq_task[h][k] = wq_task[h][k-1];
                    wq_prio[h][k] = wq_prio[h][k-1];
                end
                wq_task[h][pos] = tsk;
                wq_prio[h][pos] = prio;
                wq_len[h]++;
                r.status = pimt_pkg::ST_BLOCKED;
            end
        end
        else
        begin
            if (mx_holds[h] == 0)
                r.status = pimt_pkg::ST_UNHELD;
            else if (mx_owner[h] != tsk)
                r.status = pimt_pkg::ST_NOT_OWNER;
            else
            begin
                mx_holds[h]--;
                if (mx_holds[h] == 0)
                begin
                    if (prio != mx_base[h])
                    begin
                        r.prio_change_valid = 1'b1;
                        r.prio_change_task  = mx_owner[h];
                        r.prio_change_value = mx_base[h];
                    end
                    if (wq_len[h] != 0)
                    begin
                        mx_owner[h] = wq_task[h][0];
                        mx_base[h]  = wq_prio[h][0];
                        mx_cur[h]   = wq_prio[h][0];
                        mx_holds[h] = 8'd1;
                        r.wake_valid = 1'b1;
                        r.wake_task  = wq_task[h][0];
                        for (int k = 1; k < wq_len[h]; k++)
                        begin
                            wq_task[h][k-1] = wq_task[h][k];
                            wq_prio[h][k-1] = wq_prio[h][k];
                        end
                        wq_len[h]--;
                    end
                    else
                    begin
                        mx_owner[h] = '0;
                        mx_base[h]  = '0;
                        mx_cur[h]   = '0;
                    end
                end
            end
        end
        return r;
    endfunction

    // acceptance monitor: predicts on each command transaction, checks each result
    always @(posedge clk)
    begin
        pimt_pkg::result_t exp_r;
        pimt_pkg::result_t got;
        typed_exp_t        te;
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
            begin
                exp_r = mutex_table_step(pimt_pkg::kind_t'(cmd.kind), cmd.handle,
                                         cmd.task_id, cmd.task_priority, cmd.may_wait,
                                         cmd.in_interrupt, cmd.sched_suspended);
                te = typed_q.pop_front();
                if (te.typed)
                    exp_r = te.res;
                pending_results.push_back(exp_r);
                n_cmds++;
                if (exp_r.status == pimt_pkg::ST_BLOCKED)
                    n_blocked++;
                if (exp_r.wake_valid)
                    n_wakes++;
                if (exp_r.prio_change_valid)
                    n_boosts++;
            end
            if (res.valid && res.ready)
            begin
                got.status            = res.status;
                got.new_handle        = res.new_handle;
                got.prio_change_valid = res.prio_change_valid;
                got.prio_change_task  = res.prio_change_task;
                got.prio_change_value = res.prio_change_value;
                got.wake_valid        = res.wake_valid;
                got.wake_task         = res.wake_task;
                n_results++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: status %0d", got.status);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got != exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d mismatch: exp st=%0d nh=%0d pc=%0b/%0d/%0d",
                                      " wk=%0b/%0d, got st=%0d nh=%0d pc=%0b/%0d/%0d wk=%0b/%0d"},
                                     n_results, exp_r.status, exp_r.new_handle,
                                     exp_r.prio_change_valid, exp_r.prio_change_task,
                                     exp_r.prio_change_value, exp_r.wake_valid,
                                     exp_r.wake_task, got.status, got.new_handle,
                                     got.prio_change_valid, got.prio_change_task,
                                     got.prio_change_value, got.wake_valid, got.wake_task);
                    end
                end
            end
        end
    end

    // result side back-pressure; a long hold-off opens the last phase
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (phase == 2 && hold_count_cycles < 300)
        begin
            res.ready <= 1'b0;
            hold_count_cycles++;
        end
        else
            res.ready <= ($urandom_range(99) >= dst_idle);
    end

    task automatic send_cmd(cmd_row_t c);
        typed_exp_t te;
        if ($urandom_range(99) < src_idle)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        te.typed = c.typed;
        te.res   = '0;
        te.res.status     = c.exp_status;
        te.res.new_handle = c.exp_handle;
        typed_q.push_back(te);
        cmd.valid           <= 1'b1;
        cmd.kind            <= c.kind;
        cmd.handle          <= c.handle;
        cmd.task_id         <= c.task_id;
        cmd.task_priority   <= c.prio;
        cmd.may_wait        <= c.may_wait;
        cmd.in_interrupt    <= c.intr;
        cmd.sched_suspended <= c.susp;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    function automatic cmd_row_t mk(pimt_pkg::kind_t k, int h, int t, int p,
                                    bit w = 1'b1, bit i = 1'b0, bit s = 1'b0);
        cmd_row_t c;
        c.kind = k; c.handle = 8'(h); c.task_id = 5'(t); c.prio = 5'(p);
        c.may_wait = w; c.intr = i; c.susp = s;
        c.typed = 1'b0; c.exp_status = pimt_pkg::ST_OK; c.exp_handle = '0;
        return c;
    endfunction

    function automatic cmd_row_t mkx(cmd_row_t c, pimt_pkg::status_t st, int nh = 0);
        c.typed      = 1'b1;
        c.exp_status = st;
        c.exp_handle = 4'(nh);
        return c;
    endfunction

    function automatic cmd_row_t random_cmd();
        cmd_row_t c;
        int       r;
        r = $urandom_range(99);
        c = mk(pimt_pkg::K_LOCK, $urandom_range(pimt_pkg::NUM_MUTEXES - 1),
               ($urandom_range(1) ? $urandom_range(3) : $urandom_range(31)),
               $urandom_range(31), ($urandom_range(99) < 80),
               ($urandom_range(99) < 3), ($urandom_range(99) < 3));
        if (r < 10)
            c.kind = pimt_pkg::K_CREATE;
        else if (r < 16)
            c.kind = pimt_pkg::K_DESTROY;
        else if (r < 55)
            c.kind = pimt_pkg::K_UNLOCK;
        // a few stray handles; also reach the owner so unlocks succeed
        if ($urandom_range(99) < 6)
            c.handle = 8'($urandom_range(255));
        else if (c.kind == pimt_pkg::K_UNLOCK && mx_holds[c.handle[3:0]] != 0 &&
                 $urandom_range(99) < 75)
        begin
            c.task_id = mx_owner[c.handle[3:0]];
            if ($urandom_range(1))
                c.prio = mx_cur[c.handle[3:0]];
        end
        return c;
    endfunction

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    cmd_row_t dir_rows[$];

    initial
    begin
        rst_n               = 1'b0;
        cmd.valid           = 1'b0;
        cmd.kind            = pimt_pkg::K_CREATE;
        cmd.handle          = '0;
        cmd.task_id         = '0;
        cmd.task_priority   = '0;
        cmd.may_wait        = 1'b0;
        cmd.in_interrupt    = 1'b0;
        cmd.sched_suspended = 1'b0;
        src_idle            = 15;
        dst_idle            = 87;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows.push_back(mkx(mk(pimt_pkg::K_DESTROY, 0, 0, 0), pimt_pkg::ST_NOT_CREATED));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_LOCK, 255, 31, 31), pimt_pkg::ST_BAD_HANDLE));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_UNLOCK, 16, 0, 0), pimt_pkg::ST_BAD_HANDLE));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_CREATE, 200, 0, 0), pimt_pkg::ST_OK, 0));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_LOCK, 0, 1, 3, 1'b1, 1'b1, 1'b1),
                               pimt_pkg::ST_IN_INTR));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_LOCK, 0, 1, 3, 1'b1, 1'b0, 1'b1),
                               pimt_pkg::ST_SUSPENDED));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_UNLOCK, 0, 1, 3), pimt_pkg::ST_UNHELD));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_LOCK, 0, 1, 3), pimt_pkg::ST_OK));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_LOCK, 0, 2, 9, 1'b0), pimt_pkg::ST_TRY_FAILED));
        dir_rows.push_back(mk(pimt_pkg::K_LOCK, 0, 2, 9));
        dir_rows.push_back(mk(pimt_pkg::K_LOCK, 0, 3, 31));
        dir_rows.push_back(mk(pimt_pkg::K_LOCK, 0, 4, 9));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_UNLOCK, 0, 2, 9), pimt_pkg::ST_NOT_OWNER));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_DESTROY, 0, 1, 3), pimt_pkg::ST_HAS_WAITERS));
        dir_rows.push_back(mk(pimt_pkg::K_UNLOCK, 0, 1, 31));
        dir_rows.push_back(mk(pimt_pkg::K_UNLOCK, 0, 3, 31));
        dir_rows.push_back(mk(pimt_pkg::K_UNLOCK, 0, 2, 9));
        dir_rows.push_back(mk(pimt_pkg::K_UNLOCK, 0, 4, 9));
        dir_rows.push_back(mk(pimt_pkg::K_LOCK, 0, 31, 0));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_DESTROY, 0, 31, 0), pimt_pkg::ST_HELD));
        dir_rows.push_back(mk(pimt_pkg::K_UNLOCK, 0, 31, 0));
        dir_rows.push_back(mkx(mk(pimt_pkg::K_DESTROY, 0, 31, 0), pimt_pkg::ST_OK));
        foreach (dir_rows[i])
            send_cmd(dir_rows[i]);

        // pool exhaustion, nest ceiling and full wait queue
        for (int i = 0; i <= pimt_pkg::NUM_MUTEXES; i++)
            send_cmd(mk(pimt_pkg::K_CREATE, 0, 0, 0));
        for (int i = 0; i <= pimt_pkg::HOLD_MAX; i++)
            send_cmd(mk(pimt_pkg::K_LOCK, 0, 7, 5));
        for (int i = 0; i < pimt_pkg::HOLD_MAX; i++)
            send_cmd(mk(pimt_pkg::K_UNLOCK, 0, 7, 5));
        send_cmd(mk(pimt_pkg::K_LOCK, 1, 8, 2));
        for (int i = 0; i <= pimt_pkg::MAX_TASKS; i++)
            send_cmd(mk(pimt_pkg::K_LOCK, 1, (i % 31) + 9 > 31 ? i % 8 : (i % 23) + 9,
                        $urandom_range(31)));

        for (phase = 0; phase < 3; phase++)
        begin
            src_idle = (phase == 0) ? 15 : (phase == 1) ? 87 : 0;
            dst_idle = (phase == 0) ? 87 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < 55; n++)
                send_cmd(random_cmd());
        end
        cmd.valid <= 1'b0;
        drain();
        repeat (100) @(posedge clk);

        $display("%0d commands checked: %0d blocked locks, %0d wakes, %0d priority changes",
                 n_cmds, n_blocked, n_wakes, n_boosts);
        $display("covered error codes, pool and nest limits, a full wait queue and stalls");
        if (mismatches == 0)
            $display("priority_inheritance_mutex_table regression: pass");
        else
            $display("priority_inheritance_mutex_table regression: fail");
        $finish;
    end

endmodule
